// ===== hw/rtl/sqs_pkg.sv =====
// shared types and codes for the sequence store with insert and delete
package sqs_pkg;

  localparam int OP_W      = 3;
  localparam int POS_W     = 4;
  localparam int VAL_W     = 32;
  localparam int CNT_OUT_W = 5;
  localparam int CAP_W     = 5;
  localparam int ST_W      = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  // operation codes
  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd5;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  // capacity saturates here
  localparam logic [CAP_W-1:0] CAP_MAX = 5'd31;

  // per-cell actions broadcast along the chain
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_APPEND = 3'd1;
  localparam logic [2:0] ACT_INSERT = 3'd2;
  localparam logic [2:0] ACT_DELETE = 3'd3;
  localparam logic [2:0] ACT_WRITE  = 3'd4;

  typedef struct packed {
    logic [2:0]       act;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage

// ===== hw/rtl/sqs_cell.sv =====
// one storage cell of the chain, takes from either neighbour or loads a new word
module sqs_cell
  import sqs_pkg::*;
#(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic             clk,
  input  cell_cmd_t        cmd,
  input  logic [CW-1:0]    cnt,
  input  logic [VAL_W-1:0] left_q,
  input  logic [VAL_W-1:0] right_q,
  output logic [VAL_W-1:0] q
);

  localparam int MW = ((CW > POS_W) ? CW : POS_W) + 2;
  localparam logic [MW-1:0] IDX_C = MW'(IDX);

  logic [VAL_W-1:0] q_r;
  logic [VAL_W-1:0] q_nxt;
  logic [MW-1:0]    cnt_c;
  logic [MW-1:0]    pos_c;

  assign cnt_c = MW'(cnt);
  assign pos_c = MW'(cmd.pos);

  always_comb begin
    q_nxt = q_r;
    unique case (cmd.act)
      ACT_APPEND: begin
        if (IDX_C == cnt_c) q_nxt = cmd.value;
      end
      ACT_INSERT: begin
        if (IDX_C == pos_c) q_nxt = cmd.value;
        else if (IDX_C > pos_c && IDX_C <= cnt_c) q_nxt = left_q;
      end
      ACT_DELETE: begin
        if (IDX_C >= pos_c && (IDX_C + MW'(1)) < cnt_c) q_nxt = right_q;
      end
      ACT_WRITE: begin
        if (IDX_C == pos_c) q_nxt = cmd.value;
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// ===== hw/rtl/sqs_chain.sv =====
// row of storage cells with neighbour links and the entry read select
module sqs_chain
  import sqs_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int CW    = 5
) (
  input  logic             clk,
  input  cell_cmd_t        cmd,
  input  logic [CW-1:0]    cnt,
  output logic [VAL_W-1:0] rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [VAL_W-1:0] q [DEPTH];
  logic [AW-1:0]    rd_idx;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [VAL_W-1:0] left_q;
      logic [VAL_W-1:0] right_q;
      if (gi == 0) begin : g_first
        assign left_q = cmd.value;
      end else begin : g_mid_l
        assign left_q = q[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_q = q[gi];
      end else begin : g_mid_r
        assign right_q = q[gi+1];
      end
      sqs_cell #(.CW(CW), .IDX(gi)) u_cell (
        .clk     (clk),
        .cmd     (cmd),
        .cnt     (cnt),
        .left_q  (left_q),
        .right_q (right_q),
        .q       (q[gi])
      );
    end
  endgenerate

  // index is only used when the position is below the count
  assign rd_idx  = AW'(cmd.pos);
  assign rd_data = q[rd_idx];

endmodule

// ===== hw/rtl/sequence_store_insert_delete.sv =====
// top level: ordered word store with append, pop, insert, delete, read and write
// an accepted item's result is registered in the output register
// throughput: one item per cycle while results are taken; every chain cell shifts
// in the same cycle; a result taken by the output side lets the next item in
// reset: count and capacity clear to zero, output register empties; cell contents
//   are not cleared and are never read before being written
module sequence_store_insert_delete
  import sqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // op [2:0], position [6:3], value [38:7], zero fill [39]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // read_value [31:0], count [36:32], capacity [41:37], is_empty [42],
  // status [44:43], zero fill [47:45]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // width of the internal element count, able to hold DEPTH itself
  localparam int CW = $clog2(DEPTH + 1);
  // working width for compares and the grow and shrink arithmetic
  localparam int MW = ((CW > 6) ? CW : 6) + 3;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // input fields
  logic [OP_W-1:0]  in_op;
  logic [POS_W-1:0] in_pos;
  logic [VAL_W-1:0] in_val;

  assign in_op  = in_tdata[2:0];
  assign in_pos = in_tdata[6:3];
  assign in_val = in_tdata[38:7];

  // control state
  logic [CW-1:0]    count_r, count_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic             out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic             accept;
  cell_cmd_t        cmd;
  logic [VAL_W-1:0] rd_data;
  logic [VAL_W-1:0] rd_val;
  logic [ST_W-1:0]  status;

  // grow and shrink helpers
  logic [MW-1:0]    cnt_c, pos_c, cap_c;
  logic [CW-1:0]    cnt_dec;
  logic [MW-1:0]    dec_c;
  logic [MW-1:0]    grow_c, shrink_c;
  logic [CAP_W-1:0] cap_grow, cap_shrink;

  // a new item enters whenever the output register is free or being drained
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign cnt_c   = MW'(count_r);
  assign pos_c   = MW'(in_pos);
  assign cap_c   = MW'(cap_r);
  assign cnt_dec = count_r - CW'(1);
  assign dec_c   = MW'(cnt_dec);

  // adding while count equals capacity grows it to 2c+1, saturated
  assign grow_c   = (cap_c << 1) + MW'(1);
  assign cap_grow = (cnt_c == cap_c)
                    ? ((grow_c > MW'(CAP_MAX)) ? CAP_MAX : grow_c[CAP_W-1:0])
                    : cap_r;

  // removing shrinks to 2n+1 once four times the new count is below capacity
  assign shrink_c   = (dec_c << 1) + MW'(1);
  assign cap_shrink = ((dec_c << 2) < cap_c)
                      ? ((shrink_c > MW'(CAP_MAX)) ? CAP_MAX : shrink_c[CAP_W-1:0])
                      : cap_r;

  // decode the operation into a cell action, new count and capacity, status
  always_comb begin
    count_nxt = count_r;
    cap_nxt   = cap_r;
    status    = ST_OK;
    rd_val    = '0;
    cmd.act   = ACT_NONE;
    cmd.pos   = in_pos;
    cmd.value = in_val;
    unique case (in_op)
      OP_APPEND: begin
        if (count_r == DEPTH_C) begin
          status = ST_FULL;
        end else begin
          cmd.act   = ACT_APPEND;
          count_nxt = count_r + CW'(1);
          cap_nxt   = cap_grow;
        end
      end
      OP_POP: begin
        if (count_r == '0) begin
          status = ST_EMPTY;
        end else begin
          count_nxt = cnt_dec;
          cap_nxt   = cap_shrink;
        end
      end
      OP_INSERT: begin
        // range check takes priority over the full check
        if (pos_c > cnt_c) begin
          status = ST_RANGE;
        end else if (count_r == DEPTH_C) begin
          status = ST_FULL;
        end else begin
          cmd.act   = ACT_INSERT;
          count_nxt = count_r + CW'(1);
          cap_nxt   = cap_grow;
        end
      end
      OP_DELETE: begin
        if (pos_c >= cnt_c) begin
          status = ST_RANGE;
        end else begin
          cmd.act   = ACT_DELETE;
          count_nxt = cnt_dec;
          cap_nxt   = cap_shrink;
        end
      end
      OP_READ: begin
        if (pos_c >= cnt_c) status = ST_RANGE;
        else rd_val = rd_data;
      end
      OP_WRITE: begin
        if (pos_c >= cnt_c) status = ST_RANGE;
        else cmd.act = ACT_WRITE;
      end
      default: begin
        // undefined operations leave everything as it is
        status = ST_OK;
      end
    endcase
    // nothing moves in the chain without an accepted item
    if (!accept) cmd.act = ACT_NONE;
  end

  sqs_chain #(.DEPTH(DEPTH), .CW(CW)) u_chain (
    .clk     (clk),
    .cmd     (cmd),
    .cnt     (count_r),
    .rd_data (rd_data)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        cap_r       <= cap_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register, count is reported modulo 32
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {3'b000, status, (count_nxt == '0), cap_nxt,
                     CNT_OUT_W'(count_nxt), rd_val};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hw/rtl/sqs_checker.sv =====
// port-level checks on the sequence store, bound to the top level
module sqs_checker
  import sqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // a held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // no result is pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // the empty flag agrees with the reported count
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[42] == (out_tdata[36:32] == 5'd0)))
    else $error("empty flag disagrees with count");

  // full status only when the store holds DEPTH entries
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[44:43] == ST_FULL |-> out_tdata[36:32] == 5'(DEPTH))
    else $error("full status with count below depth");

  // a stalled result holds back further items
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("item taken while result stalled");

endmodule

bind sequence_store_insert_delete sqs_checker #(.DEPTH(DEPTH)) u_sqs_checker (.*);

// ===== tb/sequence_store_insert_delete_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the ordered word store with insert and delete
module sequence_store_insert_delete_test;
  import sqs_pkg::*;

  localparam int DEPTH       = 16;
  localparam int STALL_LIMIT = 500;

  // op codes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  // laid out msb first so that it maps straight onto out_tdata[44:0]
  typedef struct packed {
    logic [ST_W-1:0]      status;
    logic                 is_empty;
    logic [CAP_W-1:0]     capacity;
    logic [CNT_OUT_W-1:0] count;
    logic [VAL_W-1:0]     read_value;
  } store_outcome_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // op [2:0], position [6:3], value [38:7], zero fill [39]
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // read_value [31:0], count [36:32], capacity [41:37], is_empty [42],
  // status [44:43], zero fill [47:45]
  logic [OUT_DATA_W-1:0] out_tdata;

  sequence_store_insert_delete #(.DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // shadow copy of the store, its count and its logical capacity
  logic [VAL_W-1:0] shadow_words [DEPTH];
  int               shadow_count = 0;
  int               shadow_capacity = 0;

  // outcomes still owed by the block, oldest first
  store_outcome_t   owed_outcomes [$];
  int               mismatches = 0;

  // idling ranges, changed from one phase to the next
  int               in_gap_max = 9;
  int               out_stall_max = 9;
  int               quiet_cycles = 0;

  // capacity doubles plus one when an add finds the store at capacity
  function automatic void shadow_add_word();
    if (shadow_count == shadow_capacity) begin
      shadow_capacity = (2 * shadow_capacity + 1 > int'(CAP_MAX)) ?
                        int'(CAP_MAX) : 2 * shadow_capacity + 1;
    end
    shadow_count++;
  endfunction

  // capacity shrinks once the count falls below a quarter of it
  function automatic void shadow_remove_word();
    shadow_count--;
    if (4 * shadow_count < shadow_capacity) begin
      shadow_capacity = 2 * shadow_count + 1;
    end
  endfunction

  // applies one item to the shadow store and gives the outcome it must produce
  function automatic store_outcome_t predict_store_op(input logic [OP_W-1:0] op,
                                                      input logic [POS_W-1:0] pos,
                                                      input logic [VAL_W-1:0] val);
    store_outcome_t res;
    int             p;
    res = '0;
    res.status = ST_OK;
    p = int'(pos);
    case (op)
      OP_APPEND: begin
        if (shadow_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_words[shadow_count] = val;
          shadow_add_word();
        end
      end
      OP_POP: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          shadow_remove_word();
        end
      end
      OP_INSERT: begin
        // the range check wins over the full check
        if (p > shadow_count) begin
          res.status = ST_RANGE;
        end else if (shadow_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (int i = shadow_count; i > p; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[p] = val;
          shadow_add_word();
        end
      end
      OP_DELETE: begin
        if (p >= shadow_count) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = p; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
          shadow_remove_word();
        end
      end
      OP_READ: begin
        if (p >= shadow_count) res.status = ST_RANGE;
        else res.read_value = shadow_words[p];
      end
      OP_WRITE: begin
        if (p >= shadow_count) res.status = ST_RANGE;
        else shadow_words[p] = val;
      end
      default: ;
    endcase
    res.count    = CNT_OUT_W'(shadow_count);
    res.capacity = CAP_W'(shadow_capacity);
    res.is_empty = (shadow_count == 0);
    return res;
  endfunction

  // offers one item after a random gap and records its outcome once taken
  task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] val);
    int gap;
    gap = $urandom_range(in_gap_max, 0);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, val, pos, op};
    do @(posedge clk); while (!in_tready);
    owed_outcomes.push_back(predict_store_op(op, pos, val));
  endtask

  // stops offering and waits until every owed outcome has come back
  task automatic drain_outcomes();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (owed_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // a valid position for access or removal, or anything when the store is empty
  function automatic logic [POS_W-1:0] held_position();
    if (shadow_count == 0) return POS_W'($urandom_range(15, 0));
    return POS_W'($urandom_range(shadow_count - 1, 0));
  endfunction

  // values lean towards the extremes now and then
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(7, 0))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // empty store errors, unused ops, word extremes and every op on a short sequence
  task automatic test_edges_and_errors();
    in_gap_max    = 9;
    out_stall_max = 9;
    send_item(OP_POP, 4'd0, 32'd0);
    send_item(OP_DELETE, 4'd0, 32'h1234_5678);
    send_item(OP_READ, 4'd0, 32'd0);
    send_item(OP_WRITE, 4'hF, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 4'd1, 32'hDEAD_BEEF);
    send_item(OP_SPARE_6, 4'hF, 32'hFFFF_FFFF);
    send_item(OP_SPARE_7, 4'd0, 32'd0);
    send_item(OP_APPEND, 4'd0, 32'h7FFF_FFFF);
    send_item(OP_APPEND, 4'hF, 32'h8000_0000);
    send_item(OP_INSERT, 4'd0, 32'hFFFF_FFFF);
    // insert exactly at the count, in the middle, then past the count
    send_item(OP_INSERT, 4'd3, 32'd0);
    send_item(OP_INSERT, 4'd2, 32'd1);
    send_item(OP_INSERT, 4'd6, 32'h5555_5555);
    for (int i = 0; i < 5; i++) send_item(OP_READ, POS_W'(i), 32'hFFFF_FFFF);
    send_item(OP_WRITE, 4'd4, 32'hAAAA_AAAA);
    send_item(OP_READ, 4'd4, 32'd0);
    send_item(OP_DELETE, 4'd5, 32'd0);
    send_item(OP_DELETE, 4'd0, 32'd0);
    send_item(OP_DELETE, 4'd3, 32'd0);
    repeat (3) send_item(OP_POP, 4'd0, 32'd0);
    send_item(OP_POP, 4'hF, 32'd0);
  endtask

  // fill to the full depth so capacity saturates, hit the full cases, then empty out
  task automatic test_fill_and_drain();
    in_gap_max    = 3;
    out_stall_max = 9;
    while (shadow_count < DEPTH) send_item(OP_APPEND, 4'd0, pick_value());
    send_item(OP_APPEND, 4'd0, 32'h1111_1111);
    send_item(OP_INSERT, 4'd0, 32'h2222_2222);
    send_item(OP_INSERT, 4'hF, 32'h3333_3333);
    send_item(OP_READ, 4'hF, 32'd0);
    send_item(OP_WRITE, 4'hF, 32'h8000_0001);
    send_item(OP_READ, 4'hF, 32'd0);
    // hold the input off while the output side catches up
    drain_outcomes();
    while (shadow_count > 0) begin
      if ($urandom_range(1, 0)) send_item(OP_DELETE, held_position(), pick_value());
      else send_item(OP_POP, 4'd0, 32'd0);
    end
    send_item(OP_POP, 4'd0, 32'd0);
  endtask

  // mostly well-formed traffic whose drift towards growth changes per round
  task automatic test_random_sequences();
    int grow_pct;
    int pick;
    for (int round = 0; round < 16; round++) begin
      grow_pct = $urandom_range(80, 20);
      case ($urandom_range(3, 0))
        0:       begin in_gap_max = 0; out_stall_max = 0; end
        1:       begin in_gap_max = 9; out_stall_max = 0; end
        2:       begin in_gap_max = 0; out_stall_max = 9; end
        default: begin in_gap_max = 9; out_stall_max = 9; end
      endcase
      repeat (100) begin
        pick = $urandom_range(99, 0);
        if (pick < 35) begin
          if ($urandom_range(1, 0)) send_item(OP_READ, held_position(), $urandom);
          else send_item(OP_WRITE, held_position(), pick_value());
        end else if ($urandom_range(99, 0) < grow_pct) begin
          if ($urandom_range(1, 0)) begin
            send_item(OP_APPEND, POS_W'($urandom_range(15, 0)), pick_value());
          end else begin
            send_item(OP_INSERT,
                      POS_W'($urandom_range(shadow_count > 15 ? 15 : shadow_count, 0)),
                      pick_value());
          end
        end else begin
          if ($urandom_range(1, 0)) send_item(OP_POP, POS_W'($urandom_range(15, 0)), $urandom);
          else send_item(OP_DELETE, held_position(), $urandom);
        end
      end
    end
  endtask

  // unconstrained ops, positions and values, spare op codes included
  task automatic test_random_noise();
    in_gap_max    = 9;
    out_stall_max = 9;
    repeat (300) begin
      send_item(OP_W'($urandom_range(7, 0)), POS_W'($urandom_range(15, 0)), $urandom);
    end
  endtask

  // output side: a fresh stall before each result, none when the range is zero
  initial begin : result_taker
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = $urandom_range(out_stall_max, 0);
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // compares every taken result with the oldest owed outcome
  always @(posedge clk) begin
    store_outcome_t got;
    store_outcome_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = store_outcome_t'(out_tdata[$bits(store_outcome_t)-1:0]);
      if (owed_outcomes.size() == 0) begin
        $display("%0t: result expected none actual %0h", $time, out_tdata);
        mismatches++;
      end else begin
        want = owed_outcomes.pop_front();
        check_field("read_value", want.read_value, got.read_value);
        check_field("count", VAL_W'(want.count), VAL_W'(got.count));
        check_field("capacity", VAL_W'(want.capacity), VAL_W'(got.capacity));
        check_field("is_empty", VAL_W'(want.is_empty), VAL_W'(got.is_empty));
        check_field("status", VAL_W'(want.status), VAL_W'(got.status));
      end
    end
  end

  // gives up when no item moves on either side for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("sequence_store_insert_delete: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_edges_and_errors();
    test_fill_and_drain();
    test_random_sequences();
    test_random_noise();
    drain_outcomes();
    // wait on to catch any stray result
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("sequence_store_insert_delete: match");
    end else begin
      $display("sequence_store_insert_delete: mismatch");
    end
    $finish;
  end

endmodule
